### src/pis_pkg.sv
`timescale 1ns / 1ps

package pis_pkg;

   // Field widths.
   localparam int COORD_W = 32;
   localparam int DIFF_W  = COORD_W + 1;
   localparam int MAG_W   = COORD_W + 2;
   localparam int SQ_W    = 2 * COORD_W;
   localparam int SUM_W   = SQ_W + 2;
   localparam int KIND_W  = 3;
   localparam int CSR_W   = 3;

   // Pipeline depth: input register, difference, prepare, square, decide.
   localparam int STAGES = 5;

   typedef enum logic [KIND_W-1:0] {
      KIND_CIRCLE  = 3'd0,
      KIND_RECT    = 3'd1,
      KIND_SPHERE  = 3'd2,
      KIND_BOX     = 3'd3,
      KIND_CAPSULE = 3'd4
   } pis_kind_type;

   typedef enum logic [CSR_W-1:0] {
      CSR_ENABLE   = 3'd0,
      CSR_KIND     = 3'd1,
      CSR_CENTER_X = 3'd2,
      CSR_CENTER_Y = 3'd3,
      CSR_CENTER_Z = 3'd4,
      CSR_EXTENT_A = 3'd5,
      CSR_EXTENT_B = 3'd6,
      CSR_EXTENT_C = 3'd7
   } pis_csr_type;

   // Shape configuration as seen by the datapath.
   typedef struct packed {
      logic                      enable;
      logic [KIND_W-1:0]         kind;
      logic signed [COORD_W-1:0] extent_a;
      logic signed [COORD_W-1:0] extent_b;
      logic signed [COORD_W-1:0] extent_c;
   } pis_shape_type;

   // Decision flags carried down the pipeline next to the squares.
   typedef struct packed {
      logic box_pass;
      logic ball_test;
   } pis_sel_type;

endpackage

### src/point_in_shape_test_top.sv
`timescale 1ns / 1ps
// A request moves through the input, difference, prepare, square and decide registers in turn.
// Throughput: one request per clock; the five-stage pipeline moves as long as
// the result side does not stall, and a stall only backs up the stages behind it.
// Reset: synchronous and active high; it empties the pipeline and clears every
// configuration register to zero, which leaves the shape disabled.
module point_in_shape_test_top import pis_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   // Request channel: one query point.
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic signed [COORD_W-1:0] req_point_x,
   input  logic signed [COORD_W-1:0] req_point_y,
   input  logic signed [COORD_W-1:0] req_point_z,
   // Result channel.
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic                      rsp_inside_res,
   // Configuration write channel.
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_W-1:0]          csr_index,
   input  logic [COORD_W-1:0]        csr_wdata
);

   // Configuration registers. The user is to change them only while idle;
   // the block does not enforce this. The diff and prep stages read them directly.
   logic                      shape_enable_ff;
   logic [KIND_W-1:0]         shape_kind_ff;
   logic signed [COORD_W-1:0] center_x_ff;
   logic signed [COORD_W-1:0] center_y_ff;
   logic signed [COORD_W-1:0] center_z_ff;
   logic signed [COORD_W-1:0] extent_a_ff;
   logic signed [COORD_W-1:0] extent_b_ff;
   logic signed [COORD_W-1:0] extent_c_ff;

   // Input register, the first pipeline stage.
   logic signed [COORD_W-1:0] point_x_ff;
   logic signed [COORD_W-1:0] point_y_ff;
   logic signed [COORD_W-1:0] point_z_ff;

   // Stage occupancy and per-stage load enables.
   logic [STAGES-1:0] valid_ff, valid_in;
   logic [STAGES-1:0] ready;
   logic [STAGES-1:0] load;

   pis_shape_type             shape;
   logic signed [DIFF_W-1:0]  diff_x, diff_y, diff_z;
   logic [COORD_W-1:0]        mag_0, mag_1, mag_2, bound;
   pis_sel_type               prep_sel, sq_sel;
   logic [SQ_W-1:0]           sq_0, sq_1, sq_2, limit;

   // Configuration writes are always taken.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         shape_enable_ff <= 1'b0;
         shape_kind_ff   <= '0;
         center_x_ff     <= '0;
         center_y_ff     <= '0;
         center_z_ff     <= '0;
         extent_a_ff     <= '0;
         extent_b_ff     <= '0;
         extent_c_ff     <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_ENABLE:   shape_enable_ff <= csr_wdata[0];
            CSR_KIND:     shape_kind_ff   <= csr_wdata[KIND_W-1:0];
            CSR_CENTER_X: center_x_ff     <= csr_wdata;
            CSR_CENTER_Y: center_y_ff     <= csr_wdata;
            CSR_CENTER_Z: center_z_ff     <= csr_wdata;
            CSR_EXTENT_A: extent_a_ff     <= csr_wdata;
            CSR_EXTENT_B: extent_b_ff     <= csr_wdata;
            CSR_EXTENT_C: extent_c_ff     <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      shape.enable   = shape_enable_ff;
      shape.kind     = shape_kind_ff;
      shape.extent_a = extent_a_ff;
      shape.extent_b = extent_b_ff;
      shape.extent_c = extent_c_ff;
   end

   // A stage can take new data when it is empty or when its own contents
   // move on in the same cycle. The chain starts at the result register,
   // so a stalled result only holds the stages that are actually full.
   always_comb begin
      ready[STAGES-1] = !valid_ff[STAGES-1] || !rsp_stall;
      for (int k = STAGES - 2; k >= 0; k--) begin
         ready[k] = !valid_ff[k] || ready[k+1];
      end
      valid_in[0] = req_valid;
      for (int k = 1; k < STAGES; k++) begin
         valid_in[k] = valid_ff[k-1];
      end
      load = ready & valid_in;
   end

   assign req_stall = !ready[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int k = 0; k < STAGES; k++) begin
            if (ready[k]) begin
               valid_ff[k] <= valid_in[k];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load[0]) begin
         point_x_ff <= req_point_x;
         point_y_ff <= req_point_y;
         point_z_ff <= req_point_z;
      end
   end

   // Stage two: point minus center.
   pis_diff u_diff (
      .clock    (clock),
      .load     (load[1]),
      .point_x  (point_x_ff),
      .point_y  (point_y_ff),
      .point_z  (point_z_ff),
      .center_x (center_x_ff),
      .center_y (center_y_ff),
      .center_z (center_z_ff),
      .diff_x   (diff_x),
      .diff_y   (diff_y),
      .diff_z   (diff_z)
   );

   // Stage three: magnitudes, capsule clamp, box tests and range checks.
   pis_prep u_prep (
      .clock  (clock),
      .load   (load[2]),
      .diff_x (diff_x),
      .diff_y (diff_y),
      .diff_z (diff_z),
      .shape  (shape),
      .mag_0  (mag_0),
      .mag_1  (mag_1),
      .mag_2  (mag_2),
      .bound  (bound),
      .sel    (prep_sel)
   );

   // Stage four: squares of the three terms and of the radius.
   pis_square u_square (
      .clock (clock),
      .load  (load[3]),
      .mag_0 (mag_0),
      .mag_1 (mag_1),
      .mag_2 (mag_2),
      .bound (bound),
      .sel_i (prep_sel),
      .sq_0  (sq_0),
      .sq_1  (sq_1),
      .sq_2  (sq_2),
      .limit (limit),
      .sel_o (sq_sel)
   );

   // Stage five: sum against the squared radius; this is the result register.
   pis_decide u_decide (
      .clock  (clock),
      .load   (load[4]),
      .sq_0   (sq_0),
      .sq_1   (sq_1),
      .sq_2   (sq_2),
      .limit  (limit),
      .sel    (sq_sel),
      .hit    (rsp_inside_res)
   );

   assign rsp_valid = valid_ff[STAGES-1];

   // An empty pipeline never pushes back on the request side.
   assert property (@(posedge clock) disable iff (reset)
      (valid_ff == '0) |-> !req_stall)
      else $error("request stalled while the pipeline is empty");

   // With every stage full and the result held, nothing more may enter.
   assert property (@(posedge clock) disable iff (reset)
      ((&valid_ff) && rsp_stall) |-> req_stall)
      else $error("request taken while the pipeline is full and stalled");

   // An accepted request always lands in the input register.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> valid_ff[0])
      else $error("accepted request lost at the input register");

   // Reset leaves no result pending.
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

endmodule

### src/pis_diff.sv
`timescale 1ns / 1ps

module pis_diff import pis_pkg::*; (
   input  logic                      clock,
   input  logic                      load,
   input  logic signed [COORD_W-1:0] point_x,
   input  logic signed [COORD_W-1:0] point_y,
   input  logic signed [COORD_W-1:0] point_z,
   input  logic signed [COORD_W-1:0] center_x,
   input  logic signed [COORD_W-1:0] center_y,
   input  logic signed [COORD_W-1:0] center_z,
   output logic signed [DIFF_W-1:0]  diff_x,
   output logic signed [DIFF_W-1:0]  diff_y,
   output logic signed [DIFF_W-1:0]  diff_z
);

   logic signed [DIFF_W-1:0] dx_ff, dx_in;
   logic signed [DIFF_W-1:0] dy_ff, dy_in;
   logic signed [DIFF_W-1:0] dz_ff, dz_in;

   // One extra bit keeps the difference exact.
   always_comb begin
      dx_in = {point_x[COORD_W-1], point_x} - {center_x[COORD_W-1], center_x};
      dy_in = {point_y[COORD_W-1], point_y} - {center_y[COORD_W-1], center_y};
      dz_in = {point_z[COORD_W-1], point_z} - {center_z[COORD_W-1], center_z};
   end

   always_ff @(posedge clock) begin
      if (load) begin
         dx_ff <= dx_in;
         dy_ff <= dy_in;
         dz_ff <= dz_in;
      end
   end

   assign diff_x = dx_ff;
   assign diff_y = dy_ff;
   assign diff_z = dz_ff;

endmodule

### src/pis_prep.sv
`timescale 1ns / 1ps

module pis_prep import pis_pkg::*; (
   input  logic                     clock,
   input  logic                     load,
   input  logic signed [DIFF_W-1:0] diff_x,
   input  logic signed [DIFF_W-1:0] diff_y,
   input  logic signed [DIFF_W-1:0] diff_z,
   input  pis_shape_type            shape,
   output logic [COORD_W-1:0]       mag_0,
   output logic [COORD_W-1:0]       mag_1,
   output logic [COORD_W-1:0]       mag_2,
   output logic [COORD_W-1:0]       bound,
   output pis_sel_type              sel
);

   logic [COORD_W-1:0] m0_ff, m0_in;
   logic [COORD_W-1:0] m1_ff, m1_in;
   logic [COORD_W-1:0] m2_ff, m2_in;
   logic [COORD_W-1:0] b_ff, b_in;
   pis_sel_type        sel_ff, sel_in;

   logic [DIFF_W-1:0]        neg_x, neg_y, neg_z;
   logic [COORD_W-1:0]       ax, ay, az;
   logic                     ea_pos, eb_pos, ec_pos;
   logic                     x_fit, y_fit, z_fit;
   logic                     cap_long;
   logic [DIFF_W-1:0]        l2_full;
   logic signed [MAG_W-1:0]  y2, l2s, e2s;
   logic [MAG_W-1:0]         e2;
   logic [MAG_W-1:0]         m0w, m1w, m2w;
   logic [COORD_W-1:0]       bw;
   logic                     ball_en, over;

   always_comb begin
      // Magnitudes of the differences always fit in the coordinate width.
      neg_x = -diff_x;
      neg_y = -diff_y;
      neg_z = -diff_z;
      ax = diff_x[DIFF_W-1] ? neg_x[COORD_W-1:0] : diff_x[COORD_W-1:0];
      ay = diff_y[DIFF_W-1] ? neg_y[COORD_W-1:0] : diff_y[COORD_W-1:0];
      az = diff_z[DIFF_W-1] ? neg_z[COORD_W-1:0] : diff_z[COORD_W-1:0];

      ea_pos = !shape.extent_a[COORD_W-1] && (shape.extent_a != '0);
      eb_pos = !shape.extent_b[COORD_W-1] && (shape.extent_b != '0);
      ec_pos = !shape.extent_c[COORD_W-1] && (shape.extent_c != '0);

      // Half sizes are compared by doubling the distance instead.
      x_fit = {ax, 1'b0} <= {1'b0, shape.extent_a};
      y_fit = {ay, 1'b0} <= {1'b0, shape.extent_b};
      z_fit = {az, 1'b0} <= {1'b0, shape.extent_c};

      // Capsule in doubled units: segment half length L2 = h - 2r.
      cap_long = {1'b0, shape.extent_b} >= {shape.extent_a, 1'b0};
      l2_full  = {1'b0, shape.extent_b} - {shape.extent_a, 1'b0};
      y2  = {diff_y, 1'b0};
      l2s = {2'b00, l2_full[COORD_W-1:0]};
      if (y2 > l2s) begin
         e2s = y2 - l2s;
      end else if (y2 < -l2s) begin
         e2s = -(y2 + l2s);
      end else begin
         e2s = '0;
      end
      e2 = e2s;

      m0w      = {2'b00, ax};
      m1w      = {2'b00, ay};
      m2w      = '0;
      bw       = shape.extent_a;
      ball_en  = 1'b0;
      sel_in   = '0;
      case (shape.kind)
         KIND_CIRCLE: begin
            ball_en = ea_pos;
         end
         KIND_RECT: begin
            sel_in.box_pass = ea_pos && eb_pos && x_fit && y_fit;
         end
         KIND_SPHERE: begin
            m2w     = {2'b00, az};
            ball_en = ea_pos;
         end
         KIND_BOX: begin
            sel_in.box_pass = ea_pos && eb_pos && ec_pos && x_fit && y_fit && z_fit;
         end
         KIND_CAPSULE: begin
            m0w     = {1'b0, ax, 1'b0};
            m1w     = e2;
            m2w     = {1'b0, az, 1'b0};
            bw      = {shape.extent_a[COORD_W-2:0], 1'b0};
            ball_en = ea_pos && eb_pos && cap_long;
         end
         default: begin
            ball_en = 1'b0;
         end
      endcase

      // Any term beyond the radius rules the point out; otherwise the
      // terms fit in the coordinate width and the squares stay exact.
      over = (m0w > {2'b00, bw}) || (m1w > {2'b00, bw}) || (m2w > {2'b00, bw});
      sel_in.ball_test = ball_en && !over;
      sel_in.box_pass  = sel_in.box_pass && shape.enable;
      sel_in.ball_test = sel_in.ball_test && shape.enable;

      m0_in = m0w[COORD_W-1:0];
      m1_in = m1w[COORD_W-1:0];
      m2_in = m2w[COORD_W-1:0];
      b_in  = bw;
   end

   always_ff @(posedge clock) begin
      if (load) begin
         m0_ff  <= m0_in;
         m1_ff  <= m1_in;
         m2_ff  <= m2_in;
         b_ff   <= b_in;
         sel_ff <= sel_in;
      end
   end

   assign mag_0 = m0_ff;
   assign mag_1 = m1_ff;
   assign mag_2 = m2_ff;
   assign bound = b_ff;
   assign sel   = sel_ff;

endmodule

### src/pis_square.sv
`timescale 1ns / 1ps

module pis_square import pis_pkg::*; (
   input  logic               clock,
   input  logic               load,
   input  logic [COORD_W-1:0] mag_0,
   input  logic [COORD_W-1:0] mag_1,
   input  logic [COORD_W-1:0] mag_2,
   input  logic [COORD_W-1:0] bound,
   input  pis_sel_type        sel_i,
   output logic [SQ_W-1:0]    sq_0,
   output logic [SQ_W-1:0]    sq_1,
   output logic [SQ_W-1:0]    sq_2,
   output logic [SQ_W-1:0]    limit,
   output pis_sel_type        sel_o
);

   logic [SQ_W-1:0] sq0_ff, sq0_in;
   logic [SQ_W-1:0] sq1_ff, sq1_in;
   logic [SQ_W-1:0] sq2_ff, sq2_in;
   logic [SQ_W-1:0] lim_ff, lim_in;
   pis_sel_type     sel_ff;

   // Four independent 32 by 32 unsigned squares.
   always_comb begin
      sq0_in = {{COORD_W{1'b0}}, mag_0} * {{COORD_W{1'b0}}, mag_0};
      sq1_in = {{COORD_W{1'b0}}, mag_1} * {{COORD_W{1'b0}}, mag_1};
      sq2_in = {{COORD_W{1'b0}}, mag_2} * {{COORD_W{1'b0}}, mag_2};
      lim_in = {{COORD_W{1'b0}}, bound} * {{COORD_W{1'b0}}, bound};
   end

   always_ff @(posedge clock) begin
      if (load) begin
         sq0_ff <= sq0_in;
         sq1_ff <= sq1_in;
         sq2_ff <= sq2_in;
         lim_ff <= lim_in;
         sel_ff <= sel_i;
      end
   end

   assign sq_0  = sq0_ff;
   assign sq_1  = sq1_ff;
   assign sq_2  = sq2_ff;
   assign limit = lim_ff;
   assign sel_o = sel_ff;

endmodule

### src/pis_decide.sv
`timescale 1ns / 1ps

module pis_decide import pis_pkg::*; (
   input  logic            clock,
   input  logic            load,
   input  logic [SQ_W-1:0] sq_0,
   input  logic [SQ_W-1:0] sq_1,
   input  logic [SQ_W-1:0] sq_2,
   input  logic [SQ_W-1:0] limit,
   input  pis_sel_type     sel,
   output logic            hit
);

   logic             inside_ff, inside_in;
   logic [SUM_W-1:0] sum;

   always_comb begin
      sum = {2'b00, sq_0} + {2'b00, sq_1} + {2'b00, sq_2};
      inside_in = sel.box_pass || (sel.ball_test && (sum <= {2'b00, limit}));
   end

   always_ff @(posedge clock) begin
      if (load) begin
         inside_ff <= inside_in;
      end
   end

   assign hit = inside_ff;

endmodule

### bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import pis_pkg::*;

   // Q16.16 constants used to place shapes and points.
   localparam logic signed [COORD_W-1:0] ONE_Q = 32'sh0001_0000;
   localparam logic signed [COORD_W-1:0] MAX_Q = 32'sh7FFF_FFFF;
   localparam logic signed [COORD_W-1:0] MIN_Q = 32'sh8000_0000;

   // Each side idles or stalls in about this many cycles out of a hundred.
   localparam int IDLE_PCT = 14;
   // The run is declared hung after this many clock cycles.
   localparam int CYCLE_LIMIT = 200000;
   // Length of the long hold-off on the result side.
   localparam int HOLD_CYCLES = 300;

   // One expected answer, kept together with the point that caused it so
   // that a mismatch can be traced back to its request.
   typedef struct {
      logic                      hit;
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] z;
   } containment_verdict_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic signed [COORD_W-1:0] req_point_x = '0;
   logic signed [COORD_W-1:0] req_point_y = '0;
   logic signed [COORD_W-1:0] req_point_z = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic                      rsp_inside_res;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CSR_W-1:0]          csr_index = '0;
   logic [COORD_W-1:0]        csr_wdata = '0;

   // Our own copy of the shape registers, updated at each accepted write.
   logic                      shp_enable = 1'b0;
   logic [KIND_W-1:0]         shp_kind = '0;
   logic signed [COORD_W-1:0] shp_cx = '0;
   logic signed [COORD_W-1:0] shp_cy = '0;
   logic signed [COORD_W-1:0] shp_cz = '0;
   logic signed [COORD_W-1:0] shp_a = '0;
   logic signed [COORD_W-1:0] shp_b = '0;
   logic signed [COORD_W-1:0] shp_c = '0;

   containment_verdict_type pending_verdicts[$];
   int  mismatch_count = 0;
   int  cycle_count = 0;
   // When set, neither side idles, which gives a long back-to-back stretch.
   bit  quiet = 1'b0;
   // When set, the result side stalls without a break.
   bit  hold_off = 1'b0;

   point_in_shape_test_top i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_point_x    (req_point_x),
      .req_point_y    (req_point_y),
      .req_point_z    (req_point_z),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_inside_res (rsp_inside_res),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Watchdog: a run that never drains its expectations ends here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("** point_in_shape_test_top: FAILED **");
         $finish;
      end
   end

   // The result side changes its stall at the falling edge. During a hold-off
   // it stalls every cycle; otherwise it stalls at random unless the bench is
   // in its quiet stretch.
   always @(negedge clock) begin
      rsp_stall <= hold_off || (!quiet && $urandom_range(99) < IDLE_PCT);
   end

   // Exact containment test of one point against the shadow shape. The
   // working width of 80 bits holds every difference, square and sum
   // without wrapping, so plain comparisons give the exact answer. Halved
   // extents are avoided by doubling the other side of each comparison.
   function automatic logic inside_shape(logic signed [COORD_W-1:0] px,
                                         logic signed [COORD_W-1:0] py,
                                         logic signed [COORD_W-1:0] pz);
      logic signed [79:0] dx, dy, dz, ax, ay, az;
      logic signed [79:0] ra, hb, sc, y2, l2, nearest, ey;
      logic hit;
      dx = 80'(px) - 80'(shp_cx);
      dy = 80'(py) - 80'(shp_cy);
      dz = 80'(pz) - 80'(shp_cz);
      ax = (dx < 0) ? -dx : dx;
      ay = (dy < 0) ? -dy : dy;
      az = (dz < 0) ? -dz : dz;
      ra = 80'(shp_a);
      hb = 80'(shp_b);
      sc = 80'(shp_c);
      hit = 1'b0;
      if (shp_enable) begin
         case (shp_kind)
            KIND_CIRCLE: begin
               hit = (ra > 0) && (ax * ax + ay * ay <= ra * ra);
            end
            KIND_RECT: begin
               hit = (ra > 0) && (hb > 0) && (2 * ax <= ra) && (2 * ay <= hb);
            end
            KIND_SPHERE: begin
               hit = (ra > 0) && (ax * ax + ay * ay + az * az <= ra * ra);
            end
            KIND_BOX: begin
               hit = (ra > 0) && (hb > 0) && (sc > 0) && (2 * ax <= ra)
                     && (2 * ay <= hb) && (2 * az <= sc);
            end
            KIND_CAPSULE: begin
               // Work in doubled units: the core segment runs over
               // [-(h - 2r), h - 2r] in doubled y.
               if ((ra > 0) && (hb > 0) && (hb >= 2 * ra)) begin
                  y2 = 2 * dy;
                  l2 = hb - 2 * ra;
                  nearest = (y2 < -l2) ? -l2 : ((y2 > l2) ? l2 : y2);
                  ey = y2 - nearest;
                  hit = (4 * ax * ax + ey * ey + 4 * az * az <= 4 * ra * ra);
               end
            end
            default: begin
               hit = 1'b0;
            end
         endcase
      end
      return hit;
   endfunction

   // Every accepted result is compared with the oldest expectation.
   always @(posedge clock) begin : check_results
      containment_verdict_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_verdicts.size() == 0) begin
            mismatch_count++;
            $display("%t: inside_res expected no result actual %0b",
                     $realtime, rsp_inside_res);
         end else begin
            want = pending_verdicts.pop_front();
            if (rsp_inside_res !== want.hit) begin
               mismatch_count++;
               $display("%t: inside_res expected %0b actual %0b for point %h %h %h",
                        $realtime, want.hit, rsp_inside_res, want.x, want.y, want.z);
            end
         end
      end
   end

   // Offers one request, with a random idle gap in front of it, and waits
   // until the block takes it. The expectation is queued at that edge. Valid
   // stays high afterwards so that the next request can follow directly.
   task automatic send_point(logic signed [COORD_W-1:0] x,
                             logic signed [COORD_W-1:0] y,
                             logic signed [COORD_W-1:0] z);
      int gap;
      containment_verdict_type want;
      gap = 0;
      while (!quiet && $urandom_range(99) < IDLE_PCT) gap++;
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_point_x <= x;
      req_point_y <= y;
      req_point_z <= z;
      do @(posedge clock); while (req_stall);
      want.hit = inside_shape(x, y, z);
      want.x = x;
      want.y = y;
      want.z = z;
      pending_verdicts.push_back(want);
   endtask

   // Stops offering requests and waits until the pipeline is empty, so that
   // the shape registers may be changed.
   task automatic drain_pipeline();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_verdicts.size() != 0) @(posedge clock);
      repeat (STAGES + 2) @(posedge clock);
   endtask

   task automatic write_reg(pis_csr_type idx, logic [COORD_W-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_ENABLE:   shp_enable = data[0];
         CSR_KIND:     shp_kind = data[KIND_W-1:0];
         CSR_CENTER_X: shp_cx = data;
         CSR_CENTER_Y: shp_cy = data;
         CSR_CENTER_Z: shp_cz = data;
         CSR_EXTENT_A: shp_a = data;
         CSR_EXTENT_B: shp_b = data;
         CSR_EXTENT_C: shp_c = data;
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Drains the pipeline and then programs the whole shape. The enable and
   // kind writes carry random upper bits, which the block must ignore.
   task automatic set_shape(logic en, logic [KIND_W-1:0] kind,
                            logic signed [COORD_W-1:0] cx,
                            logic signed [COORD_W-1:0] cy,
                            logic signed [COORD_W-1:0] cz,
                            logic signed [COORD_W-1:0] a,
                            logic signed [COORD_W-1:0] b,
                            logic signed [COORD_W-1:0] c);
      logic [COORD_W-1:0] noise;
      drain_pipeline();
      noise = $urandom;
      write_reg(CSR_KIND, {noise[COORD_W-1:KIND_W], kind});
      write_reg(CSR_CENTER_X, cx);
      write_reg(CSR_CENTER_Y, cy);
      write_reg(CSR_CENTER_Z, cz);
      write_reg(CSR_EXTENT_A, a);
      write_reg(CSR_EXTENT_B, b);
      write_reg(CSR_EXTENT_C, c);
      noise = $urandom;
      write_reg(CSR_ENABLE, {noise[COORD_W-1:1], en});
   endtask

   function automatic logic signed [COORD_W-1:0] corner_coord();
      case ($urandom_range(3))
         0: return MIN_Q;
         1: return MAX_Q;
         2: return '0;
         default: return -32'sd1;
      endcase
   endfunction

   // Any value at all, with the extremes weighted up.
   function automatic logic signed [COORD_W-1:0] wild_coord();
      if ($urandom_range(9) < 3) return corner_coord();
      return $urandom;
   endfunction

   // Mostly modest positive sizes across many magnitudes, with a share of
   // zero, negative and extreme values.
   function automatic logic signed [COORD_W-1:0] rand_extent();
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 5) return '0;
      if (pick < 10) return MIN_Q | $urandom;
      if (pick < 14) return MAX_Q;
      if (pick < 17) return 32'sd1;
      return $urandom_range(32'h7FFF_FFFF, 1) >> $urandom_range(30, 0);
   endfunction

   // Centers sit near the origin most of the time.
   function automatic logic signed [COORD_W-1:0] rand_center();
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 70) return $signed($urandom_range(32'h000F_FFFF, 0)) - 32'sh0008_0000;
      if (pick < 85) return $urandom;
      return corner_coord();
   endfunction

   // A coordinate within span of mid, wrapping at the ends of the range.
   function automatic logic signed [COORD_W-1:0] near_coord(logic signed [COORD_W-1:0] mid,
                                                            longint span);
      longint unsigned draw;
      longint offset;
      draw = {$urandom, $urandom};
      offset = longint'(draw % longint'(2 * span + 1)) - span;
      return COORD_W'(longint'(mid) + offset);
   endfunction

   // Most points land around the shape so that both answers and the
   // boundaries come up often; the rest are anywhere in the field range.
   task automatic send_random_point();
      longint span;
      span = 1;
      if (shp_a > span) span = shp_a;
      if (shp_b > span) span = shp_b;
      if (shp_c > span) span = shp_c;
      span = span + span / 2;
      if ($urandom_range(99) < 85)
         send_point(near_coord(shp_cx, span), near_coord(shp_cy, span),
                    near_coord(shp_cz, span));
      else
         send_point(wild_coord(), wild_coord(), wild_coord());
   endtask

   task automatic random_shape();
      logic [KIND_W-1:0] kind;
      logic signed [COORD_W-1:0] a, b;
      longint height;
      if ($urandom_range(99) < 88) kind = KIND_W'($urandom_range(KIND_CAPSULE, KIND_CIRCLE));
      else kind = KIND_W'($urandom_range((1 << KIND_W) - 1, int'(KIND_CAPSULE) + 1));
      a = rand_extent();
      b = rand_extent();
      // Capsules are mostly made tall enough to be valid, sometimes exactly
      // twice the radius.
      if (kind == KIND_CAPSULE && a > 0 && $urandom_range(3) != 0) begin
         height = 2 * longint'(a) + (longint'(a) >> $urandom_range(31, 0));
         if (height > MAX_Q) height = MAX_Q;
         b = COORD_W'(height);
      end
      set_shape($urandom_range(99) < 90, kind, rand_center(), rand_center(),
                rand_center(), a, b, rand_extent());
   endtask

   // After reset the shape is disabled, and disabling a good shape gives
   // outside as well.
   task automatic test_disabled_shape();
      send_point('0, '0, '0);
      send_point(MIN_Q, MAX_Q, MIN_Q);
      set_shape(1'b0, KIND_CIRCLE, '0, '0, '0, 4 * ONE_Q, ONE_Q, ONE_Q);
      send_point('0, '0, '0);
   endtask

   // The circle ignores z, so a boundary point with an extreme z is inside.
   task automatic test_circle();
      set_shape(1'b1, KIND_CIRCLE, ONE_Q, -ONE_Q, '0, 2 * ONE_Q, '0, MIN_Q);
      send_point(3 * ONE_Q, -ONE_Q, MAX_Q);
      send_point(ONE_Q, ONE_Q + 1, '0);
   endtask

   task automatic test_rectangle();
      set_shape(1'b1, KIND_RECT, '0, '0, '0, 4 * ONE_Q, 2 * ONE_Q, -32'sd1);
      send_point(2 * ONE_Q, -ONE_Q, MIN_Q);
      send_point(-2 * ONE_Q - 1, '0, '0);
      send_point('0, ONE_Q + 1, '0);
   endtask

   // A maximal sphere in the most negative corner: differences reach past
   // 32 bits.
   task automatic test_sphere();
      set_shape(1'b1, KIND_SPHERE, MIN_Q, MIN_Q, MIN_Q, MAX_Q, '0, '0);
      send_point(MAX_Q, MIN_Q, MIN_Q);
      send_point(-32'sd1, MIN_Q, MIN_Q);
      send_point(MIN_Q, MAX_Q, MIN_Q);
   endtask

   task automatic test_box();
      set_shape(1'b1, KIND_BOX, '0, '0, '0, MAX_Q, MAX_Q, MAX_Q);
      send_point(32'sh3FFF_FFFF, 32'shC000_0001, '0);
      send_point(MIN_Q, '0, '0);
      send_point('0, '0, 32'sh4000_0000);
   endtask

   // End caps, the side wall, a capsule that degenerates to a sphere and one
   // that is too short to exist.
   task automatic test_capsule();
      set_shape(1'b1, KIND_CAPSULE, '0, '0, '0, ONE_Q, 4 * ONE_Q, '0);
      send_point('0, 2 * ONE_Q, '0);
      send_point('0, -2 * ONE_Q - 1, '0);
      send_point(ONE_Q, ONE_Q, '0);
      send_point('0, '0, ONE_Q + 1);
      set_shape(1'b1, KIND_CAPSULE, '0, '0, '0, ONE_Q, 2 * ONE_Q, '0);
      send_point('0, ONE_Q, '0);
      set_shape(1'b1, KIND_CAPSULE, '0, '0, '0, ONE_Q, 2 * ONE_Q - 1, '0);
      send_point('0, '0, '0);
   endtask

   task automatic test_invalid_kinds();
      for (int k = int'(KIND_CAPSULE) + 1; k < (1 << KIND_W); k++) begin
         set_shape(1'b1, KIND_W'(k), '0, '0, '0, ONE_Q, 4 * ONE_Q, ONE_Q);
         send_point('0, '0, '0);
      end
   endtask

   // A zero or negative extent that the kind uses means the center is outside.
   task automatic test_bad_extents();
      set_shape(1'b1, KIND_CIRCLE, '0, '0, '0, '0, ONE_Q, ONE_Q);
      send_point('0, '0, '0);
      set_shape(1'b1, KIND_RECT, '0, '0, '0, ONE_Q, -ONE_Q, ONE_Q);
      send_point('0, '0, '0);
      set_shape(1'b1, KIND_BOX, '0, '0, '0, ONE_Q, ONE_Q, '0);
      send_point('0, '0, '0);
   endtask

   task automatic test_random_shapes();
      repeat (42) begin
         random_shape();
         repeat (30) send_random_point();
      end
   endtask

   // Requests and results move every cycle with no idling on either side.
   task automatic test_streaming();
      random_shape();
      quiet = 1'b1;
      repeat (60) send_random_point();
      drain_pipeline();
      quiet = 1'b0;
   endtask

   task automatic hold_results(int cycles);
      @(posedge clock);
      hold_off = 1'b1;
      repeat (cycles) @(posedge clock);
      hold_off = 1'b0;
   endtask

   // The result side holds off for a long stretch while requests keep
   // coming, so the pipeline fills and pushes back on the request side.
   task automatic test_backpressure();
      random_shape();
      fork
         hold_results(HOLD_CYCLES);
         repeat (40) send_random_point();
      join
   endtask

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_disabled_shape();
      test_circle();
      test_rectangle();
      test_sphere();
      test_box();
      test_capsule();
      test_invalid_kinds();
      test_bad_extents();
      test_random_shapes();
      test_streaming();
      test_backpressure();

      // Wait for every outstanding result, then a little longer to catch
      // anything extra the block might still emit.
      drain_pipeline();
      repeat (4 * STAGES) @(posedge clock);
      if (mismatch_count == 0 && pending_verdicts.size() == 0)
         $display("** point_in_shape_test_top: PASSED **");
      else
         $display("** point_in_shape_test_top: FAILED **");
      $finish;
   end

endmodule

### filelist.f
src/pis_pkg.sv
src/pis_diff.sv
src/pis_prep.sv
src/pis_square.sv
src/pis_decide.sv
src/point_in_shape_test_top.sv
bench/tb_top.sv
